@@ sv/pbrd_pkg.sv @@
`default_nettype none

package pbrd_pkg;

  // Bytes packed into one result beat, held within the width of data_word.
  localparam int unsigned BYTES_PER_RESULT = 4;
  localparam int unsigned BEAT_BYTES =
    (BYTES_PER_RESULT < 1) ? 1 : ((BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT);

  localparam int unsigned ROW_LEN_W     = 12;
  localparam int unsigned RUN_W         = 8;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 12'd72;

  // Header byte decode
  localparam logic [7:0] HDR_REPEAT_MIN = 8'd128;

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  // Register map: register index taken from paddr[2]
  localparam int unsigned APB_ADDR_W    = 3;
  localparam logic        REG_ROW_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_BAD_FORMAT    = 2'd1,
    ST_PREMATURE_END = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_of_burst;
    logic        row_done;
    status_e     status;
  } out_t;

  // One unit of back-end work: repeat data_byte count times (count is 1 for a
  // literal, 0 for an error beat), then close the row if done is set.
  typedef struct packed {
    logic [7:0]     data_byte;
    logic [RUN_W-1:0] count;
    logic           done;
    status_e        status;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/pbrd_front.sv @@
`default_nettype none

module pbrd_front import pbrd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire in_t                  item_i,
  input  wire logic                 restart_i,
  input  wire logic [ROW_LEN_W-1:0] row_len_i,
  output logic                      cmd_push_o,
  output cmd_t                      cmd_o
);

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_LIT = 3'b010,
    PH_REP = 3'b100
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [RUN_W-1:0]       run_left_q, run_left_d;
  logic [ROW_LEN_W-1:0]   row_left_q, row_left_d;
  logic [ROW_LEN_W-1:0]   lit_cnt, rep_cnt, row_after;
  logic                   restart_row;

  assign lit_cnt = ROW_LEN_W'(item_i.code_byte) + ROW_LEN_W'(1);
  assign rep_cnt = ROW_LEN_W'(run_left_q) + ROW_LEN_W'(1);

  always_comb begin
    phase_d     = phase_q;
    run_left_d  = run_left_q;
    row_left_d  = row_left_q;
    row_after   = row_left_q;
    restart_row = 1'b0;
    cmd_push_o  = 1'b0;
    cmd_o       = '{data_byte: item_i.code_byte, count: '0, done: 1'b0, status: ST_OK};
    if (restart_i) begin
      restart_row = 1'b1;
    end else if (accept_i) begin
      if (item_i.end_of_input) begin
        cmd_push_o  = 1'b1;
        cmd_o.done  = 1'b1;
        cmd_o.status = (phase_q == PH_REP && rep_cnt > row_left_q) ?
                       ST_BAD_FORMAT : ST_PREMATURE_END;
        restart_row = 1'b1;
      end else begin
        unique case (phase_q)
          PH_LIT: begin
            run_left_d = run_left_q - RUN_W'(1);
            row_after  = row_left_q - ROW_LEN_W'(1);
            row_left_d = row_after;
            if (run_left_d == '0) begin
              phase_d = PH_HDR;
            end
            cmd_push_o  = 1'b1;
            cmd_o.count = RUN_W'(1);
            cmd_o.done  = (row_after == '0);
            restart_row = (row_after == '0);
          end
          PH_REP: begin
            cmd_push_o = 1'b1;
            if (rep_cnt > row_left_q) begin
              cmd_o.done   = 1'b1;
              cmd_o.status = ST_BAD_FORMAT;
              restart_row  = 1'b1;
            end else begin
              row_after   = row_left_q - rep_cnt;
              row_left_d  = row_after;
              phase_d     = PH_HDR;
              run_left_d  = '0;
              cmd_o.count = rep_cnt[RUN_W-1:0];
              cmd_o.done  = (row_after == '0);
              restart_row = (row_after == '0);
            end
          end
          default: begin
            // Header byte; an unknown phase code is taken as a header too.
            if (item_i.code_byte < HDR_REPEAT_MIN) begin
              if (lit_cnt > row_left_q) begin
                cmd_push_o   = 1'b1;
                cmd_o.done   = 1'b1;
                cmd_o.status = ST_BAD_FORMAT;
                restart_row  = 1'b1;
              end else begin
                phase_d    = PH_LIT;
                run_left_d = lit_cnt[RUN_W-1:0];
              end
            end else begin
              phase_d    = PH_REP;
              run_left_d = RUN_W'(9'd256 - {1'b0, item_i.code_byte});
            end
          end
        endcase
      end
    end
    if (restart_row) begin
      phase_d    = PH_HDR;
      run_left_d = '0;
      row_left_d = row_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      run_left_q <= '0;
      row_left_q <= ROW_LEN_RESET;
    end else begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
      row_left_q <= row_left_d;
    end
  end

  a_lit_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LIT |-> run_left_q != '0)
    else $error("literal phase with no bytes left in the run");

  a_row_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(restart_i) |-> row_left_q == $past(row_len_i))
    else $error("row restart did not reload the row length");

endmodule

`default_nettype wire

@@ sv/pbrd_cmd_fifo.sv @@
`default_nettype none

module pbrd_cmd_fifo import pbrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      count_q <= count_q + (CMD_PTR_W+1)'(do_push) - (CMD_PTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/pbrd_back.sv @@
`default_nettype none

module pbrd_back import pbrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_empty_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_t      result_o
);

  logic             started_q, started_d;
  logic [RUN_W-1:0] left_q, left_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic [RUN_W-1:0] cur_left, take, left_after;
  logic             slot_free, emit;
  logic [31:0]      word;

  assign slot_free  = !out_valid_q || pop_i;
  assign emit       = slot_free && !cmd_empty_i;
  assign cur_left   = started_q ? left_q : cmd_i.count;
  assign take       = (cur_left < RUN_W'(BEAT_BYTES)) ? cur_left : RUN_W'(BEAT_BYTES);
  assign left_after = cur_left - take;

  always_comb begin
    word = '0;
    for (int i = 0; i < BEAT_BYTES; i++) begin
      if (RUN_W'(i) < take) begin
        word[8*i +: 8] = cmd_i.data_byte;
      end
    end
  end

  always_comb begin
    started_d   = started_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.data_word     = word;
      out_d.byte_count    = take[2:0];
      out_d.last_of_burst = (left_after == '0);
      out_d.row_done      = (left_after == '0) && cmd_i.done;
      out_d.status        = cmd_i.status;
      if (left_after == '0) begin
        cmd_pop_o = 1'b1;
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        left_d    = left_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    out_q  <= out_d;
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  a_error_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |->
      out_q.byte_count == '0 && out_q.row_done && out_q.last_of_burst)
    else $error("error beat carries data or is not the end of a row");

  a_mid_burst_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last_of_burst |-> out_q.byte_count == 3'(BEAT_BYTES))
    else $error("beat inside a burst is not full");

endmodule

`default_nettype wire

@@ sv/packbits_row_decoder_top.sv @@
// PackBits row decoder.
// Input queue (push/full, item_i): one coded byte per transaction, or an end
// of input marker. Output queue (empty/pop, result_o): decoded beats of up to
// four bytes, first byte in bits 7:0; last_of_burst marks the final beat of an
// input transaction, row_done closes a row (complete, bad format or premature
// end, given in status).
// A front stage tracks header/literal/repeat phase and the bytes left in the
// row and posts one command per data byte or error into a 4-deep queue; a back
// stage expands each command into beats and holds them in an output register.
// The first result of a transaction passes through the command queue and then
// the output register before it shows on result_o.
// Throughput: one input transaction per cycle while the command queue has
// room; a repeat byte holds the back stage for its ceil(count/4) beats (up to 33),
// the back stage being the limit. Header bytes yield no result.
// A stalled receiver (pop low) holds the output register, the back stage then
// stops and, once the command queue fills, full rises.
// Reset: row length 72, row restarts, both queues empty. A write to the row
// length register over APB (address 0) restarts the row at once; write it
// only while the block is idle.
`default_nettype none

module packbits_row_decoder_top import pbrd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input queue
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   item_i,
  // output queue
  output logic                       empty,
  input  wire logic                  pop,
  output out_t                       result_o,
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [ROW_LEN_W-1:0] row_len_q, row_len_d;
  logic                 cfg_write;
  logic                 item_accept;
  logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t                 cmd_in, cmd_head;

  // Register access: write completes in the access phase, pready tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ROW_LENGTH);
  assign row_len_d = cfg_write ? pwdata[ROW_LEN_W-1:0] : row_len_q;
  assign prdata    = (paddr[2] == REG_ROW_LENGTH) ? 32'(row_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= ROW_LEN_RESET;
    end else begin
      row_len_q <= row_len_d;
    end
  end

  // Take an item only while the command queue can absorb whatever it yields.
  assign full        = cmd_full;
  assign item_accept = push && !cmd_full;

  pbrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (item_accept),
    .item_i     (item_i),
    .restart_i  (cfg_write),
    .row_len_i  (row_len_d),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  pbrd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .head_o  (cmd_head)
  );

  // Expand commands into beats; the output register decouples the receiver.
  pbrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

@@ sim/packbits_row_monitor.sv @@
`timescale 1ns / 1ps

// Watches both queue channels and the register port of the row decoder,
// decodes each accepted coded byte into the beats it must produce, and
// compares each popped beat with the oldest one still owed.
module packbits_row_monitor
  import pbrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_t                   item_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_t                  result_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic [31:0]           prdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           rows_o,
  output int unsigned           errors_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  out_t owed_beats[$];

  phase_e               phase;
  logic [RUN_W-1:0]     run_left;
  logic [ROW_LEN_W-1:0] row_left;
  logic [ROW_LEN_W-1:0] row_len;

  int unsigned fails = 0;
  int unsigned checked = 0;
  int unsigned rows = 0;
  int unsigned errors = 0;
  int unsigned owed = 0;

  assign fail_count_o = fails;
  assign pending_o    = owed;
  assign checked_o    = checked;
  assign rows_o       = rows;
  assign errors_o     = errors;

  function automatic void restart_row();
    phase    = PH_HEADER;
    run_left = '0;
    row_left = row_len;
  endfunction

  function automatic void owe_beat(logic [31:0] word, int unsigned cnt, logic done,
                                   status_e st);
    out_t b;
    b.data_word     = word;
    b.byte_count    = 3'(cnt);
    b.last_of_burst = 1'b0;
    b.row_done      = done;
    b.status        = st;
    owed_beats.push_back(b);
  endfunction

  function automatic void owe_error(status_e st);
    owe_beat('0, 0, 1'b1, st);
    restart_row();
  endfunction

  // Advance the row state by one coded byte and queue the beats it yields.
  function automatic void decode_code_byte(in_t it);
    int unsigned owed_at_entry;
    int unsigned count;
    int unsigned left;
    int unsigned take;
    logic [31:0] word;
    out_t        tail;
    owed_at_entry = owed_beats.size();
    if (it.end_of_input) begin
      // a repeat that could never fit outranks the early end
      if (phase == PH_REPEAT && int'(run_left) + 1 > int'(row_left))
        owe_error(ST_BAD_FORMAT);
      else
        owe_error(ST_PREMATURE_END);
    end else begin
      case (phase)
        PH_LITERAL: begin
          run_left = run_left - 1'b1;
          row_left = row_left - 1'b1;
          if (run_left == 0) phase = PH_HEADER;
          owe_beat({24'b0, it.code_byte}, 1, row_left == 0, ST_OK);
          if (row_left == 0) restart_row();
        end
        PH_REPEAT: begin
          count = int'(run_left) + 1;
          if (count > row_left) begin
            owe_error(ST_BAD_FORMAT);
          end else begin
            row_left = row_left - ROW_LEN_W'(count);
            phase    = PH_HEADER;
            run_left = '0;
            left     = count;
            while (left > 0) begin
              take = (left < BEAT_BYTES) ? left : BEAT_BYTES;
              word = '0;
              for (int i = 0; i < int'(take); i++) word[8*i +: 8] = it.code_byte;
              left = left - take;
              owe_beat(word, take, left == 0 && row_left == 0, ST_OK);
            end
            if (row_left == 0) restart_row();
          end
        end
        default: begin
          if (it.code_byte < HDR_REPEAT_MIN) begin
            count = int'(it.code_byte) + 1;
            if (count > row_left) begin
              owe_error(ST_BAD_FORMAT);
            end else begin
              phase    = PH_LITERAL;
              run_left = RUN_W'(count);
            end
          end else begin
            phase    = PH_REPEAT;
            run_left = RUN_W'(256 - int'(it.code_byte));
          end
        end
      endcase
    end
    if (owed_beats.size() > owed_at_entry) begin
      tail = owed_beats.pop_back();
      tail.last_of_burst = 1'b1;
      owed_beats.push_back(tail);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%t %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_beat(out_t got);
    out_t want;
    if (owed_beats.size() == 0) begin
      fails++;
      $display("%t unexpected result: expected none, got %h", $time, got);
    end else begin
      want = owed_beats.pop_front();
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
      compare_field("last_of_burst", 32'(want.last_of_burst), 32'(got.last_of_burst));
      compare_field("row_done", 32'(want.row_done), 32'(got.row_done));
      compare_field("status", 32'(want.status), 32'(got.status));
      checked++;
      if (want.row_done) rows++;
      if (want.status != ST_OK) errors++;
    end
  endfunction

  // Results first: a beat popped at this edge can never stem from a byte
  // pushed at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_beats.delete();
      row_len = ROW_LEN_RESET;
      restart_row();
    end else begin
      if (pop_i && !empty_i) check_beat(result_i);
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_ROW_LENGTH) begin
        if (pwrite_i) begin
          row_len = pwdata_i[ROW_LEN_W-1:0];
          restart_row();
        end else begin
          compare_field("row_length readback", 32'(row_len), 32'(prdata_i[ROW_LEN_W-1:0]));
        end
      end
      if (push_i && !full_i) decode_code_byte(item_i);
    end
    owed = owed_beats.size();
  end

endmodule

@@ sim/tb_packbits_row_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_packbits_row_decoder_top;
  import pbrd_pkg::*;

  // Stimulus budget and timing
  localparam int unsigned ITEM_GOAL     = 320;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 8;     // header bytes still in flight
  localparam int unsigned FINAL_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transaction at all

  // Coding constants: repeat header is 257 minus the copy count
  localparam int unsigned REPEAT_BASE = 257;
  localparam int unsigned MAX_LITERAL = 128;
  localparam int unsigned MAX_REPEAT  = 129;
  localparam int unsigned MAX_ROW_LEN = 4095;

  localparam logic [APB_ADDR_W-1:0] ROW_LENGTH_ADDR = {REG_ROW_LENGTH, 2'b00};

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  push    = 1'b0;
  logic                  full;
  in_t                   item    = '0;
  logic                  empty;
  logic                  pop     = 1'b0;
  out_t                  result;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned owed_beats;
  int unsigned beats_checked;
  int unsigned rows_closed;
  int unsigned rows_failed;

  int unsigned items_sent    = 0;
  int unsigned length_writes = 0;
  int unsigned burst_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned rx_cycle      = 0;
  int unsigned rx_mode       = 0;
  bit          hold_req      = 1'b0;

  packbits_row_decoder_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item),
    .empty   (empty),
    .pop     (pop),
    .result_o(result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  packbits_row_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .item_i      (item),
    .empty_i     (empty),
    .pop_i       (pop),
    .result_i    (result),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .fail_count_o(fail_count),
    .pending_o   (owed_beats),
    .checked_o   (beats_checked),
    .rows_o      (rows_closed),
    .errors_o    (rows_failed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one coded transaction and hold it until the decoder takes it.
  // Bursts of random length are separated by random gaps; a zero gap keeps
  // push high straight into the next burst.
  task automatic offer(logic [7:0] code, logic eoi);
    int unsigned gap;
    @(negedge clk_i);
    push <= 1'b1;
    item <= '{code_byte: code, end_of_input: eoi};
    do @(posedge clk_i); while (full);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(7, 0);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] code);
    offer(code, 1'b0);
  endtask

  // The byte beside an end marker is ignored, so randomise it.
  task automatic send_end();
    offer(8'($urandom), 1'b1);
  endtask

  // Drop push, wait until every owed beat has been popped, then let any
  // header byte still inside the decoder settle before touching registers.
  task automatic quiesce();
    @(negedge clk_i);
    push <= 1'b0;
    while (owed_beats != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the row length, then read it straight back. Upper data bits are
  // random and must be dropped by the register.
  task automatic write_row_length(int unsigned len);
    quiesce();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ROW_LENGTH_ADDR;
    pwdata  <= ($urandom & ~32'hFFF) | (len & 32'hFFF);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    length_writes++;
  endtask

  // Mostly short runs, now and then anything up to the limit.
  function automatic int unsigned pick_run(int unsigned lo, int unsigned hi);
    if (hi <= lo + 6 || $urandom_range(9, 0) == 0) return $urandom_range(hi, lo);
    return $urandom_range(lo + 6, lo);
  endfunction

  // Emit well-formed literal and repeat runs totalling exactly want bytes.
  task automatic send_stream(int unsigned want);
    int unsigned done;
    int unsigned cap;
    int unsigned count;
    done = 0;
    while (done < want) begin
      cap = want - done;
      if (cap >= 2 && $urandom_range(1, 0) == 1) begin
        count = pick_run(2, (cap < MAX_REPEAT) ? cap : MAX_REPEAT);
        send_byte(8'(REPEAT_BASE - count));
        send_byte(8'($urandom));
      end else begin
        count = pick_run(1, (cap < MAX_LITERAL) ? cap : MAX_LITERAL);
        send_byte(8'(count - 1));
        repeat (count) send_byte(8'($urandom));
      end
      done += count;
    end
  endtask

  // Spoil a row with left bytes still missing. Every branch ends in an
  // error or an end marker, so the next row starts clean.
  task automatic break_row(int unsigned left);
    int unsigned c;
    int unsigned k;
    case ($urandom_range(5, 0))
      0: send_end();
      1: begin
        // end of input partway through a literal run
        if (left >= 2) begin
          c = $urandom_range((left < MAX_LITERAL) ? left : MAX_LITERAL, 2);
          k = $urandom_range(c - 1, 0);
          send_byte(8'(c - 1));
          repeat (k) send_byte(8'($urandom));
        end
        send_end();
      end
      2: begin
        // end of input while the repeat byte is awaited
        c = $urandom_range(MAX_REPEAT, 2);
        send_byte(8'(REPEAT_BASE - c));
        send_end();
      end
      3: begin
        // literal run longer than the row has room for
        if (left < MAX_LITERAL) send_byte(8'($urandom_range(MAX_LITERAL - 1, left)));
        else send_end();
      end
      4: begin
        // repeat run longer than the row has room for
        if (left < MAX_REPEAT) begin
          c = $urandom_range(MAX_REPEAT, left + 1);
          send_byte(8'(REPEAT_BASE - c));
          send_byte(8'($urandom));
        end else begin
          send_end();
        end
      end
      default: begin
        repeat ($urandom_range(6, 2)) send_byte(8'($urandom));
        send_end();
      end
    endcase
  endtask

  // Receiver: a stall pattern that switches at random among four modes, plus one long
  // hold-off on request, counted here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(3, 0);
        case (rx_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(1, 0));
          2:       pop <= (rx_cycle % 4 == 0);
          default: pop <= ($urandom_range(7, 0) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned row_len;
    int unsigned prefix;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    burst_left = $urandom_range(30, 1);

    // Directed part, on the reset length of 72
    send_end();                                  // end marker at the start of a row
    send_byte(8'd0);   send_byte(8'h00);         // shortest literal run
    send_byte(8'd127);                           // longest literal header, too long here
    send_byte(8'd128); send_byte(8'hFF);         // longest repeat, judged on its data byte
    send_byte(8'd255); send_byte(8'h5A);         // shortest repeat
    send_byte(8'd128); send_end();               // end while an oversized repeat waits
    send_byte(8'd254); send_end();               // end while a fitting repeat waits
    send_byte(8'd2);   send_byte(8'h80); send_end();
    send_byte(8'd5);                             // leave a literal pending across the write

    // Shortest row: the write must drop the pending literal run
    write_row_length(1);
    send_byte(8'd0);   send_byte(8'h7F);         // one literal fills the row
    send_byte(8'd255); send_byte(8'h01);         // two copies cannot fit

    // Zero length: every header overflows
    write_row_length(0);
    send_byte(8'd0);
    send_byte(8'd200); send_byte(8'h33);
    send_end();

    // One maximal repeat filling the row exactly: 33 beats
    write_row_length(MAX_REPEAT);
    send_byte(8'd128); send_byte(8'hAA);

    // Back-pressure: longest row, receiver held off while maximal repeats
    // keep coming, so the command queue fills and full must rise
    write_row_length(MAX_ROW_LEN);
    hold_req = 1'b1;
    repeat (12) begin
      send_byte(8'(REPEAT_BASE - MAX_REPEAT));
      send_byte(8'($urandom));
    end
    send_end();

    // Random part: mostly well-formed rows, the rest spoilt
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(19, 0))
        0:              row_len = MAX_ROW_LEN;
        1, 2:           row_len = $urandom_range(400, 101);
        3, 4, 5, 6, 7:  row_len = $urandom_range(100, 25);
        default:        row_len = $urandom_range(24, 1);
      endcase
      write_row_length(row_len);
      repeat ($urandom_range(4, 1)) begin
        if (items_sent >= ITEM_GOAL) break;
        if ($urandom_range(3, 0) != 0 && row_len <= 400) begin
          send_stream(row_len);
        end else begin
          prefix = $urandom_range((row_len - 1 < 300) ? row_len - 1 : 300, 0);
          send_stream(prefix);
          break_row(row_len - prefix);
        end
      end
    end

    quiesce();
    repeat (FINAL_CYCLES) @(negedge clk_i);

    $display("Covered %0d coded transactions across %0d row-length settings.",
             items_sent, length_writes + 1);
    $display("Checked %0d result beats; %0d rows closed, %0d of them by an error.",
             beats_checked, rows_closed, rows_failed);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
